[hdl/imm_pkg.sv]
// ----------------------------------------------------------------------------
// Integer matrix multiply package
// Shared constants, codes and transfer structures of the matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

   localparam int MAX_DIM_DEFAULT    = 8;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int ELEM_W      = 32;
   localparam int IDX_W       = 3;
   localparam int DIM_REG_W   = 4;
   localparam int TYPE_REG_W  = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam int CMD_DEPTH   = 2;
   localparam int RSP_DEPTH   = 4;

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROWS_M    = 2'd0,
      CSR_INNER_K   = 2'd1,
      CSR_COLS_N    = 2'd2,
      CSR_ELEM_TYPE = 2'd3
   } csr_index_type;

   typedef enum logic [TYPE_REG_W-1:0] {
      ELEM_INT8  = 2'd0,
      ELEM_INT16 = 2'd1,
      ELEM_INT32 = 2'd2
   } elem_kind_type;

   typedef enum logic [1:0] {
      CMD_LOAD_A,
      CMD_LOAD_B,
      CMD_COMPUTE
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

   // Configuration as seen by the back end: last valid index of each
   // dimension, already clamped to the store size.
   typedef struct packed {
      logic [IDX_W-1:0]      last_row;
      logic [IDX_W-1:0]      last_inner;
      logic [IDX_W-1:0]      last_col;
      logic [TYPE_REG_W-1:0] elem_kind;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [ELEM_W-1:0] element;
   } cmd_type;

   typedef struct packed {
      logic [ELEM_W-1:0] product_value;
      logic [IDX_W-1:0]  out_row;
      logic [IDX_W-1:0]  out_col;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic             first;
      logic             last_inner;
      logic             last_all;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } step_type;

endpackage

[hdl/imm_fifo.sv]
// ----------------------------------------------------------------------------
// Small synchronous queue
// First-in first-out buffer of registers with a fill count.
// ----------------------------------------------------------------------------
module imm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hdl/imm_front.sv]
// ----------------------------------------------------------------------------
// Matrix multiply front end
// Holds the configuration registers, classifies incoming items and queues
// the ones that need work for the back end.
// ----------------------------------------------------------------------------
module imm_front import imm_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [1:0]             req_operation,
   input  logic [IDX_W-1:0]       req_row_index,
   input  logic [IDX_W-1:0]       req_col_index,
   input  logic [ELEM_W-1:0]      req_element,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg,
   input  logic                   cmd_pop,
   output cmd_type                cmd,
   output logic                   cmd_empty
);

   logic [DIM_REG_W-1:0]  rows_m_ff, inner_k_ff, cols_n_ff;
   logic [TYPE_REG_W-1:0] elem_type_ff;
   logic                  accept, in_range, enqueue;
   cmd_type               cmd_new;
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

   function automatic logic [IDX_W-1:0] last_index(input logic [DIM_REG_W-1:0] dim);
      logic [IDX_W-1:0] lim;
      if (dim == '0) begin
         lim = '0;
      end else if (dim > DIM_REG_W'(MAX_DIM)) begin
         lim = IDX_W'(MAX_DIM - 1);
      end else begin
         lim = IDX_W'(dim - 1'b1);
      end
      return lim;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff    <= DIM_REG_W'(8);
         inner_k_ff   <= DIM_REG_W'(8);
         cols_n_ff    <= DIM_REG_W'(8);
         elem_type_ff <= ELEM_INT32;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ROWS_M:    rows_m_ff    <= csr_data;
            CSR_INNER_K:   inner_k_ff   <= csr_data;
            CSR_COLS_N:    cols_n_ff    <= csr_data;
            CSR_ELEM_TYPE: elem_type_ff <= csr_data[TYPE_REG_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.last_row   = last_index(rows_m_ff);
   assign cfg.last_inner = last_index(inner_k_ff);
   assign cfg.last_col   = last_index(cols_n_ff);
   assign cfg.elem_kind  = elem_type_ff;

   assign accept   = req_push & ~req_full;
   assign in_range = (int'(req_row_index) < MAX_DIM) && (int'(req_col_index) < MAX_DIM);

   // Loads outside the store and the unused operation code are accepted and
   // dropped here; they never reach the back end.
   always_comb begin
      cmd_new.row     = req_row_index;
      cmd_new.col     = req_col_index;
      cmd_new.element = req_element;
      cmd_new.kind    = CMD_COMPUTE;
      enqueue         = 1'b0;
      case (req_operation)
         OP_LOAD_A: begin
            cmd_new.kind = CMD_LOAD_A;
            enqueue      = accept & in_range;
         end
         OP_LOAD_B: begin
            cmd_new.kind = CMD_LOAD_B;
            enqueue      = accept & in_range;
         end
         OP_COMPUTE: begin
            cmd_new.kind = CMD_COMPUTE;
            enqueue      = accept;
         end
         default: enqueue = 1'b0;
      endcase
   end

   imm_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (enqueue),
      .wr_data(cmd_new),
      .full   (req_full),
      .pop    (cmd_pop),
      .rd_data(cmd),
      .empty  (cmd_empty),
      .count  (cmd_count)
   );

   // The command count is not needed here beyond the full flag.
   logic unused_count;
   assign unused_count = ^cmd_count;

endmodule

[hdl/imm_back.sv]
// ----------------------------------------------------------------------------
// Matrix multiply back end
// Writes loaded elements to the two stores and runs the multiply-accumulate
// sequence of a compute command, one step per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module imm_back import imm_pkg::*; #(
   parameter int MAX_DIM    = MAX_DIM_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  cmd_type                        cmd,
   input  logic                           cmd_empty,
   output logic                           cmd_pop,
   input  logic [$clog2(RSP_DEPTH+1)-1:0] rsp_count,
   output logic                           rsp_push,
   output rsp_type                        rsp_data
);

   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int W16    = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;

   logic [DATA_WIDTH-1:0] store_a_ff [DEPTH];
   logic [DATA_WIDTH-1:0] store_b_ff [DEPTH];

   back_state_type state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, t_ff, t_in;
   logic             issue, load_a, load_b;
   logic [ADDR_W-1:0] wr_addr, addr_a, addr_b;
   step_type          step;

   logic [DATA_WIDTH-1:0] a_rd_ff, b_rd_ff;
   logic                  s1_valid_ff, s2_valid_ff;
   step_type              s1_tag_ff, s2_tag_ff;
   logic [ELEM_W-1:0]     prod_ff, acc_ff, acc_next;
   logic [1:0]            pending;
   logic                  room;
   logic                  at_t, at_j, at_i;
   logic [4:0]            sign_bit;

   assign wr_addr = ADDR_W'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
   assign addr_a  = ADDR_W'(int'(i_ff) * MAX_DIM + int'(t_ff));
   assign addr_b  = ADDR_W'(int'(t_ff) * MAX_DIM + int'(j_ff));

   assign at_t = (IDX_W'(t_ff) == cfg.last_inner);
   assign at_j = (IDX_W'(j_ff) == cfg.last_col);
   assign at_i = (IDX_W'(i_ff) == cfg.last_row);

   // A step is issued only when the result queue has room for every result
   // still in flight, so the pipeline never needs to stall.
   assign pending = 2'(s1_valid_ff & s1_tag_ff.last_inner)
                  + 2'(s2_valid_ff & s2_tag_ff.last_inner);
   assign room    = (int'(rsp_count) + int'(pending)) < RSP_DEPTH;

   assign step.first      = (t_ff == '0);
   assign step.last_inner = at_t;
   assign step.last_all   = at_t & at_j & at_i;
   assign step.row        = IDX_W'(i_ff);
   assign step.col        = IDX_W'(j_ff);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      t_in     = t_ff;
      cmd_pop  = 1'b0;
      issue    = 1'b0;
      load_a   = 1'b0;
      load_b   = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_LOAD_A: load_a = 1'b1;
                  CMD_LOAD_B: load_b = 1'b1;
                  CMD_COMPUTE: begin
                     state_in = BK_RUN;
                     i_in     = '0;
                     j_in     = '0;
                     t_in     = '0;
                  end
                  default: ;
               endcase
            end
         end
         BK_RUN: begin
            if (room) begin
               issue = 1'b1;
               t_in  = t_ff + 1'b1;
               if (at_t) begin
                  t_in = '0;
                  j_in = j_ff + 1'b1;
                  if (at_j) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                     if (at_i) begin
                        state_in = BK_IDLE;
                     end
                  end
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         t_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         t_ff     <= t_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         store_a_ff[wr_addr] <= cmd.element[DATA_WIDTH-1:0];
      end
      if (load_b) begin
         store_b_ff[wr_addr] <= cmd.element[DATA_WIDTH-1:0];
      end
      if (issue) begin
         a_rd_ff <= store_a_ff[addr_a];
         b_rd_ff <= store_b_ff[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Arithmetic modulo 2^32 keeps the low bits of every narrower width
   // exact, so only the final result is cut to the element width.
   always_ff @(posedge clock) begin
      s1_tag_ff <= step;
      s2_tag_ff <= s1_tag_ff;
      prod_ff   <= ELEM_W'(ELEM_W'(a_rd_ff) * ELEM_W'(b_rd_ff));
      if (s2_valid_ff) begin
         acc_ff <= acc_next;
      end
   end

   assign acc_next = s2_tag_ff.first ? prod_ff : acc_ff + prod_ff;

   always_comb begin
      case (cfg.elem_kind)
         ELEM_INT8:  sign_bit = 5'(8 - 1);
         ELEM_INT16: sign_bit = 5'(W16 - 1);
         default:    sign_bit = 5'(DATA_WIDTH - 1);
      endcase
   end

   always_comb begin
      for (int b = 0; b < ELEM_W; b++) begin
         rsp_data.product_value[b] = (5'(b) <= sign_bit) ? acc_next[b] : acc_next[sign_bit];
      end
      rsp_data.out_row = s2_tag_ff.row;
      rsp_data.out_col = s2_tag_ff.col;
      rsp_data.last    = s2_tag_ff.last_all;
   end

   assign rsp_push = s2_valid_ff & s2_tag_ff.last_inner;

endmodule

[hdl/integer_matrix_multiply_top.sv]
// ----------------------------------------------------------------------------
// Integer matrix multiply
// Loads two matrices element by element and streams out their product.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the request queue (req_push, req_full); a transfer
// happens at a clock edge with req_push high and req_full low. Operation
// zero loads A[row][col], operation one loads B[row][col], operation two
// computes C = A x B; code three is taken and dropped, as are loads whose
// row or column lies beyond the store. Results leave through the response
// queue (rsp_empty, rsp_pop) in row-major order, rsp_last marking the final
// element of C. Configuration (csr_write_en, csr_index, csr_data) sets the
// sizes M, K, N and the element width; the user writes it only while the
// block idles, which the block itself does not enforce. The back end writes
// each load to its store. A compute runs M*N*K multiply-accumulate steps,
// one per cycle while the response queue has room, on one multiplier fed
// by registered reads of the two stores; each element of C is pushed as
// its last step leaves the product register. A response queue short of
// room for the results in flight pauses the step sequencer; a busy back
// end fills the two-entry command queue, which raises req_full.
// Reset sets M = K = N = 8 and int32; the element stores are not cleared.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_top import imm_pkg::*; #(
   parameter int MAX_DIM    = MAX_DIM_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [1:0]             req_operation,
   input  logic [IDX_W-1:0]       req_row_index,
   input  logic [IDX_W-1:0]       req_col_index,
   input  logic signed [ELEM_W-1:0] req_element,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic signed [ELEM_W-1:0] rsp_product_value,
   output logic [IDX_W-1:0]       rsp_out_row,
   output logic [IDX_W-1:0]       rsp_out_col,
   output logic                   rsp_last,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg;
   cmd_type cmd;
   logic    cmd_empty, cmd_pop;
   logic    rsp_push, rsp_full;
   rsp_type rsp_new, rsp_head;
   logic [$clog2(RSP_DEPTH+1)-1:0] rsp_count;

   // Front end: configuration registers, item classification, command queue.
   imm_front #(
      .MAX_DIM(MAX_DIM)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_operation(req_operation),
      .req_row_index(req_row_index),
      .req_col_index(req_col_index),
      .req_element  (req_element),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg),
      .cmd_pop      (cmd_pop),
      .cmd          (cmd),
      .cmd_empty    (cmd_empty)
   );

   // Back end: element stores and the multiply-accumulate sequencer.
   imm_back #(
      .MAX_DIM   (MAX_DIM),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .cmd_empty(cmd_empty),
      .cmd_pop  (cmd_pop),
      .rsp_count(rsp_count),
      .rsp_push (rsp_push),
      .rsp_data (rsp_new)
   );

   // Result queue. The back end reserves room before it issues a step, so a
   // push never meets a full queue.
   imm_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .wr_data(rsp_new),
      .full   (rsp_full),
      .pop    (rsp_pop),
      .rd_data(rsp_head),
      .empty  (rsp_empty),
      .count  (rsp_count)
   );

   logic unused_full;
   assign unused_full = rsp_full;

   assign rsp_product_value = rsp_head.product_value;
   assign rsp_out_row       = rsp_head.out_row;
   assign rsp_out_col       = rsp_head.out_col;
   assign rsp_last          = rsp_head.last;

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer matrix multiply testbench
// Loads A and B element by element, runs products at several sizes and
// element widths, and compares every streamed product with its own copy of
// the multiplier kept inside this bench.
// ----------------------------------------------------------------------------
module tb_top;
   import imm_pkg::*;

   // Square size of the element stores and the number of entries in each.
   localparam int DIM = MAX_DIM_DEFAULT;
   localparam int STORE_WORDS = DIM * DIM;

   // The request port takes code three and drops it; the package has no name
   // for it, nor for the fourth element type, which behaves as int32.
   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam logic [1:0] ELEM_RESERVED = 2'd3;

   // Cycles left to the block after the last product before the sizes are
   // rewritten: a dropped item or a trailing load may still be in flight.
   localparam int SETTLE_CYCLES = 24;
   // Cycles without any transfer or register write before the run is given up.
   localparam int WATCHDOG_LIMIT = 3000;
   // Accepted items of the random part, ignored codes not counted.
   localparam int RANDOM_ITEMS = 30;
   // Beyond this many reported mismatches the report goes quiet.
   localparam int REPORT_CAP = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [1:0]             req_operation = OP_LOAD_A;
   logic [IDX_W-1:0]       req_row_index = '0;
   logic [IDX_W-1:0]       req_col_index = '0;
   logic [ELEM_W-1:0]      req_element = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [ELEM_W-1:0]      rsp_product_value;
   logic [IDX_W-1:0]       rsp_out_row;
   logic [IDX_W-1:0]       rsp_out_col;
   logic                   rsp_last;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ROWS_M;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Bench copy of the block: its registers as written and both stores.
   logic [DIM_REG_W-1:0]  rows_m = 4'd8;
   logic [DIM_REG_W-1:0]  inner_k = 4'd8;
   logic [DIM_REG_W-1:0]  cols_n = 4'd8;
   logic [TYPE_REG_W-1:0] elem_kind = ELEM_INT32;
   logic [ELEM_W-1:0]     a_store [STORE_WORDS];
   logic [ELEM_W-1:0]     b_store [STORE_WORDS];
   // The stores power up undefined, so an entry is only ever used once it
   // has been loaded; these flags say which ones have.
   bit                    a_written [STORE_WORDS];
   bit                    b_written [STORE_WORDS];

   // Products still owed by the block, oldest first.
   rsp_type     expected_products[$];
   int unsigned mismatches = 0;
   int unsigned items_sent = 0;
   int unsigned quiet_cycles = 0;
   // While set, neither side leaves gaps between transfers.
   bit          no_gaps = 1'b0;

   integer_matrix_multiply_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_operation     (req_operation),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element       (req_element),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_product_value (rsp_product_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_last          (rsp_last),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Model of the multiplier
   // ------------------------------------------------------------------------

   // A size register of zero behaves as one and anything past the store
   // behaves as the full store.
   function automatic int unsigned clamp_dim(logic [DIM_REG_W-1:0] d);
      if (d == 0)
         return 1;
      if (d > DIM)
         return DIM;
      return d;
   endfunction

   function automatic int unsigned elem_bits();
      case (elem_kind)
         ELEM_INT8:  return 8;
         ELEM_INT16: return 16;
         default:    return 32;
      endcase
   endfunction

   function automatic logic [ELEM_W-1:0] sign_extend(logic [ELEM_W-1:0] v, int unsigned w);
      case (w)
         8:       return {{24{v[7]}}, v[7:0]};
         16:      return {{16{v[15]}}, v[15:0]};
         default: return v;
      endcase
   endfunction

   // Works out every element of C in row-major order. Each sum is carried at
   // 32 bits: its low bits wrap exactly as the narrow sum would, so cutting
   // it down to the element width once at the end gives the same value.
   task automatic predict_product();
      int unsigned m, k, n, w;
      logic [ELEM_W-1:0] sum, a, b;
      rsp_type r;
      m = clamp_dim(rows_m);
      k = clamp_dim(inner_k);
      n = clamp_dim(cols_n);
      w = elem_bits();
      for (int unsigned i = 0; i < m; i++) begin
         for (int unsigned j = 0; j < n; j++) begin
            sum = '0;
            for (int unsigned t = 0; t < k; t++) begin
               a = sign_extend(a_store[i * DIM + t], w);
               b = sign_extend(b_store[t * DIM + j], w);
               sum = sum + a * b;
            end
            r.product_value = sign_extend(sum, w);
            r.out_row = IDX_W'(i);
            r.out_col = IDX_W'(j);
            r.last = (i == m - 1) && (j == n - 1);
            expected_products.push_back(r);
         end
      end
   endtask

   // Brings the bench copy up to date with one accepted item. Three-bit
   // indexes cannot leave the store, so every load lands.
   task automatic apply_item(logic [1:0] op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                             logic [ELEM_W-1:0] elem);
      case (op)
         OP_LOAD_A: begin
            a_store[row * DIM + col] = elem;
            a_written[row * DIM + col] = 1'b1;
         end
         OP_LOAD_B: begin
            b_store[row * DIM + col] = elem;
            b_written[row * DIM + col] = 1'b1;
         end
         OP_COMPUTE: begin
            predict_product();
         end
         default: begin
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offers one item and waits for its transfer. Push is left high on
   // return, so back-to-back items run without a gap; anything that waits
   // afterwards must lower it first.
   task automatic push_item(logic [1:0] op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                            logic [ELEM_W-1:0] elem);
      if (!no_gaps && $urandom_range(0, 99) < 13) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_operation <= op;
      req_row_index <= row;
      req_col_index <= col;
      req_element <= elem;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      apply_item(op, row, col, elem);
      if (op != OP_RESERVED)
         items_sent++;
   endtask

   // Stops offering items and holds off until every owed product has been
   // taken, then gives the block time to finish anything that owes nothing.
   task automatic wait_for_drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_products.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         CSR_ROWS_M:    rows_m = value;
         CSR_INNER_K:   inner_k = value;
         CSR_COLS_N:    cols_n = value;
         CSR_ELEM_TYPE: elem_kind = value[TYPE_REG_W-1:0];
         default: ;
      endcase
   endtask

   // Only ever called with the block idle. The enable stays high across the
   // four writes and drops in the step of the last one.
   task automatic set_sizes(logic [DIM_REG_W-1:0] m, logic [DIM_REG_W-1:0] k,
                            logic [DIM_REG_W-1:0] n, logic [TYPE_REG_W-1:0] kind);
      write_register(CSR_ROWS_M, m);
      write_register(CSR_INNER_K, k);
      write_register(CSR_COLS_N, n);
      write_register(CSR_ELEM_TYPE, {2'b00, kind});
      csr_write_en <= 1'b0;
   endtask

   // Mostly arbitrary words, with a good share of the edges that matter to
   // the narrow types: the largest and smallest 32-bit values, small signed
   // numbers, and words whose low byte or half sits on its sign boundary.
   function automatic logic [ELEM_W-1:0] random_element();
      logic [ELEM_W-1:0] v;
      v = $urandom();
      case ($urandom_range(0, 6))
         0: v = 32'h7FFF_FFFF;
         1: v = 32'h8000_0000;
         2: v = 32'($urandom_range(0, 8)) - 32'd4;
         3: v[15:0] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         4: v[7:0] = $urandom_range(0, 1) ? 8'h7F : 8'h80;
         default: ;
      endcase
      return v;
   endfunction

   // Mostly small sizes, now and then zero, the full store or beyond it.
   function automatic logic [DIM_REG_W-1:0] random_dim();
      case ($urandom_range(0, 9))
         0:       return 4'd0;
         1:       return DIM_REG_W'(8 + $urandom_range(0, 7));
         2:       return DIM_REG_W'($urandom_range(5, 8));
         default: return DIM_REG_W'($urandom_range(1, 4));
      endcase
   endfunction

   // Loads every element that the next product will read and that has
   // never been loaded, so no product ever reads an undefined entry.
   task automatic fill_operands();
      int unsigned m, k, n;
      m = clamp_dim(rows_m);
      k = clamp_dim(inner_k);
      n = clamp_dim(cols_n);
      for (int unsigned i = 0; i < m; i++)
         for (int unsigned t = 0; t < k; t++)
            if (!a_written[i * DIM + t])
               push_item(OP_LOAD_A, IDX_W'(i), IDX_W'(t), random_element());
      for (int unsigned t = 0; t < k; t++)
         for (int unsigned j = 0; j < n; j++)
            if (!b_written[t * DIM + j])
               push_item(OP_LOAD_B, IDX_W'(t), IDX_W'(j), random_element());
   endtask

   task automatic push_compute();
      fill_operands();
      push_item(OP_COMPUTE, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                $urandom());
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // The receiver refuses about one cycle in eight, except in the gap-free
   // stretch.
   always @(posedge clock) begin
      if (reset)
         rsp_pop <= 1'b0;
      else
         rsp_pop <= no_gaps || ($urandom_range(0, 99) >= 13);
   end

   task automatic report_field(string field, logic [ELEM_W-1:0] want, logic [ELEM_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // Each product transfer is matched against the oldest owed product.
   always @(posedge clock) begin : product_check
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_products.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t ns: unexpected product, expected none, actual %0h at %0d,%0d",
                        $time, rsp_product_value, rsp_out_row, rsp_out_col);
         end else begin
            want = expected_products.pop_front();
            report_field("product_value", want.product_value, rsp_product_value);
            report_field("out_row", 32'(want.out_row), 32'(rsp_out_row));
            report_field("out_col", 32'(want.out_col), 32'(rsp_out_col));
            report_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // Counts cycles in which nothing moves; a hung block ends the run here.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles, %0d products still owed",
                  $time, WATCHDOG_LIMIT, expected_products.size());
         $display("tb_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Sizes and type straight out of reset are 8 x 8 x 8 in int32, so every
   // element of both stores is loaded before the first product.
   task automatic test_reset_sizes();
      push_compute();
      wait_for_drain();
   endtask

   // int8: the low byte alone counts. 0x80 times 0xFF is -128 times -1, and
   // the +128 it gives wraps back to -128; 0x7F squared leaves 1.
   task automatic test_byte_wrap();
      set_sizes(4'd1, 4'd1, 4'd1, ELEM_INT8);
      push_item(OP_LOAD_A, 3'd0, 3'd0, 32'h1234_5680);
      push_item(OP_LOAD_B, 3'd0, 3'd0, 32'h0000_00FF);
      push_compute();
      push_item(OP_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FF7F);
      push_item(OP_LOAD_B, 3'd0, 3'd0, 32'h0000_007F);
      push_compute();
      wait_for_drain();
   endtask

   // int16 with a sum of three products and both half-word extremes.
   task automatic test_halfword_sums();
      set_sizes(4'd2, 4'd3, 4'd2, ELEM_INT16);
      push_item(OP_LOAD_A, 3'd0, 3'd0, 32'h1234_7FFF);
      push_item(OP_LOAD_A, 3'd0, 3'd1, 32'h0000_8000);
      push_item(OP_LOAD_A, 3'd0, 3'd2, 32'hFFFF_7FFF);
      push_item(OP_LOAD_B, 3'd0, 3'd0, 32'h0000_7FFF);
      push_item(OP_LOAD_B, 3'd1, 3'd0, 32'hFFFF_8000);
      push_item(OP_LOAD_B, 3'd2, 3'd1, 32'h8000_8000);
      push_compute();
      wait_for_drain();
   endtask

   // A rows register of zero behaves as one, fifteen and nine behave as the
   // full store, and type three behaves as int32. The corner entries carry
   // the 32-bit extremes, whose products overflow.
   task automatic test_clamped_sizes();
      set_sizes(4'd0, 4'd15, 4'd9, ELEM_RESERVED);
      push_item(OP_LOAD_A, 3'd0, 3'd7, 32'h8000_0000);
      push_item(OP_LOAD_B, 3'd7, 3'd7, 32'h8000_0000);
      push_item(OP_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
      push_item(OP_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
      push_item(OP_LOAD_B, 3'd7, 3'd0, 32'hFFFF_FFFF);
      push_compute();
      wait_for_drain();
   endtask

   // Code three is taken and dropped: it must neither write a store nor
   // produce anything, whatever its other fields hold.
   task automatic test_ignored_code();
      set_sizes(4'd2, 4'd2, 4'd8, ELEM_INT32);
      push_item(OP_RESERVED, 3'd0, 3'd0, 32'hFFFF_FFFF);
      push_item(OP_RESERVED, 3'd7, 3'd7, 32'h0000_0000);
      push_item(OP_RESERVED, 3'd1, 3'd1, 32'h5A5A_A5A5);
      push_compute();
      wait_for_drain();
   endtask

   // Random jobs: fresh sizes and type, a handful of loads mostly inside the
   // region the product reads, now and then a dropped code or a stray load,
   // then one or two products. The first three jobs run with no gaps on
   // either side.
   task automatic test_random_jobs();
      int unsigned first_item, job, m, k, n;
      logic [1:0] op;
      logic [IDX_W-1:0] row, col;
      first_item = items_sent;
      job = 0;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         no_gaps = (job < 3);
         set_sizes(random_dim(), random_dim(), random_dim(), TYPE_REG_W'($urandom_range(0, 3)));
         m = clamp_dim(rows_m);
         k = clamp_dim(inner_k);
         n = clamp_dim(cols_n);
         repeat ($urandom_range(1, 10)) begin
            op = $urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A;
            if ($urandom_range(0, 9) < 8) begin
               row = IDX_W'($urandom_range(0, (op == OP_LOAD_A ? m : k) - 1));
               col = IDX_W'($urandom_range(0, (op == OP_LOAD_A ? k : n) - 1));
            end else begin
               row = IDX_W'($urandom_range(0, 7));
               col = IDX_W'($urandom_range(0, 7));
            end
            push_item(op, row, col, random_element());
         end
         if ($urandom_range(0, 4) == 0)
            push_item(OP_RESERVED, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                      $urandom());
         repeat ($urandom_range(1, 2)) push_compute();
         wait_for_drain();
         job++;
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_sizes();
      test_byte_wrap();
      test_halfword_sums();
      test_clamped_sizes();
      test_ignored_code();
      test_random_jobs();

      wait_for_drain();
      if (mismatches == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
